FILE: sv/assert_macros.svh
// assertion macros used by the top level of the distance unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property that must hold whenever the condition holds
`define VDM_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("vdm assertion failed");
// property that must hold in the cycle after the condition
`define VDM_ASSERT_NXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("vdm assertion failed");
`else
`define VDM_ASSERT_IMP(label, clk, rst_n, cond, prop)
`define VDM_ASSERT_NXT(label, clk, rst_n, cond, prop)
`endif
`endif

FILE: sv/vdm_pkg.sv
// types, constants and saturating adders of the distance unit
package vdm_pkg;

    localparam int AccW  = 48;
    localparam int IterW = 50;
    localparam int MulW  = 25;

    typedef enum logic [1:0] {
        METRIC_L1   = 2'd0,
        METRIC_L2   = 2'd1,
        METRIC_LINF = 2'd2,
        METRIC_COS  = 2'd3
    } metric_t;

    typedef enum logic [1:0] {
        SQ_MAIN   = 2'd0,
        SQ_TARGET = 2'd1,
        SQ_QUERY  = 2'd2
    } sq_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_SQ_GO,
        S_SQ_WAIT,
        S_PROD,
        S_CMP,
        S_DIV_WAIT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic            start;
        logic            div_mode;
        logic [AccW-1:0] num;
        logic [AccW-1:0] den;
    } iter_cmd_t;

    // msb is the clip flag
    function automatic logic [AccW:0] uadd_sat(logic [AccW-1:0] acc, logic [AccW-1:0] inc);
        logic [AccW:0] s;
        s = {1'b0, acc} + {1'b0, inc};
        if (s[AccW])
            return {1'b1, {AccW{1'b1}}};
        return s;
    endfunction

    function automatic logic [AccW:0] sadd_sat(logic [AccW-1:0] acc, logic [AccW-1:0] inc);
        logic [AccW:0] s;
        s = {acc[AccW-1], acc} + {inc[AccW-1], inc};
        if (s[AccW] != s[AccW-1])
            return {1'b1, s[AccW], {(AccW-1){~s[AccW]}}};
        return {1'b0, s[AccW-1:0]};
    endfunction

endpackage

FILE: sv/vector_distance_metric_unit.sv
// top level of the vector distance unit: sequencer, accumulators and result register
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | in_valid, in_stall, target_elem,          | in
//           | query_elem, last_elem                     |
//  output   | out_valid, out_stall, score, undefined,   | out
//           | saturated                                 |
//  config   | metric_we, metric_wdata                   | in
//
// an element pair holds in_stall high after it is taken, through the multiply and accumulate states
// (three rounds for cosine) of the one shared multiplier, so no pair is taken before the last is done
// the last pair then goes on: to the output for L1 and L-infinity, through one square root in the
// shared compare-subtract unit for L2, and for cosine through two roots, a product and up to 31 divide steps
// reset sets the metric to L2 and clears the accumulators; there is no clearing pass
// the result waits in an output register; a new result waits while it is stalled

module vector_distance_metric_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] target_elem,
    input  logic signed [15:0] query_elem,
    input  logic               last_elem,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] score,
    output logic               undefined,
    output logic               saturated,
    input  logic               metric_we,
    input  logic [1:0]         metric_wdata
);

    vdm_pkg::state_t  state_reg, state_next;
    vdm_pkg::metric_t metric_reg;
    vdm_pkg::sq_sel_t sq_sel_reg;
    logic [1:0]       ph_reg;

    logic signed [15:0] t_reg, q_reg;
    logic               last_reg;

    logic [vdm_pkg::AccW-1:0] acc_reg, te_reg, qe_reg;
    logic                     clip_reg, undef_reg, ovf_reg;
    logic [23:0]              sa_reg, sb_reg;

    logic signed [31:0] score_reg;
    logic               out_valid_reg, undefined_reg, saturated_reg;

    logic                            mul_en;
    logic signed [vdm_pkg::MulW-1:0] mul_a, mul_b;
    logic signed [2*vdm_pkg::MulW-1:0] prod;
    vdm_pkg::iter_cmd_t              iter_cmd;
    logic                            iter_busy;
    logic [31:0]                     iter_res;

    logic                     accept, out_load;
    logic signed [16:0]       diff;
    logic [16:0]              ad;
    logic [vdm_pkg::AccW-1:0] mag;
    logic                     neg;
    logic [vdm_pkg::AccW:0]   add_res;
    logic signed [31:0]       score_calc;
    logic                     sat_calc;

    vdm_mul u_mul
    (
        .clk  (clk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    vdm_iter u_iter
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (iter_cmd),
        .busy   (iter_busy),
        .result (iter_res)
    );

    assign accept = in_valid && !in_stall;
    assign diff   = {t_reg[15], t_reg} - {q_reg[15], q_reg};
    assign ad     = diff[16] ? 17'(-diff) : 17'(diff);
    assign neg    = acc_reg[vdm_pkg::AccW-1];
    assign mag    = neg ? -acc_reg : acc_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vdm_pkg::S_IDLE:
                if (accept)
                    state_next = vdm_pkg::S_MUL;
            vdm_pkg::S_MUL:
                state_next = vdm_pkg::S_ACC;
            vdm_pkg::S_ACC:
            begin
                if (metric_reg == vdm_pkg::METRIC_COS && ph_reg != 2'd2)
                    state_next = vdm_pkg::S_MUL;
                else if (!last_reg)
                    state_next = vdm_pkg::S_IDLE;
                else if (metric_reg == vdm_pkg::METRIC_L2 || metric_reg == vdm_pkg::METRIC_COS)
                    state_next = vdm_pkg::S_SQ_GO;
                else
                    state_next = vdm_pkg::S_OUT;
            end
            vdm_pkg::S_SQ_GO:
                state_next = vdm_pkg::S_SQ_WAIT;
            vdm_pkg::S_SQ_WAIT:
            begin
                if (!iter_busy)
                begin
                    unique case (sq_sel_reg)
                        vdm_pkg::SQ_MAIN:   state_next = vdm_pkg::S_OUT;
                        vdm_pkg::SQ_TARGET: state_next = vdm_pkg::S_SQ_GO;
                        default:
                            state_next = (sa_reg == '0 || iter_res[23:0] == '0) ?
                                         vdm_pkg::S_OUT : vdm_pkg::S_PROD;
                    endcase
                end
            end
            vdm_pkg::S_PROD:
                state_next = vdm_pkg::S_CMP;
            vdm_pkg::S_CMP:
                state_next = ({1'b0, mag} >= {prod[vdm_pkg::AccW-1:0], 1'b0}) ?
                             vdm_pkg::S_OUT : vdm_pkg::S_DIV_WAIT;
            vdm_pkg::S_DIV_WAIT:
                if (!iter_busy)
                    state_next = vdm_pkg::S_OUT;
            vdm_pkg::S_OUT:
                if (!out_valid_reg || !out_stall)
                    state_next = vdm_pkg::S_IDLE;
            default:
                state_next = vdm_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        iter_cmd = '0;
        out_load = 1'b0;
        unique case (state_reg)
            vdm_pkg::S_MUL:
            begin
                mul_en = 1'b1;
                if (metric_reg != vdm_pkg::METRIC_COS)
                begin
                    mul_a = vdm_pkg::MulW'(diff);
                    mul_b = vdm_pkg::MulW'(diff);
                end
                else
                begin
                    unique case (ph_reg)
                        2'd0:
                        begin
                            mul_a = vdm_pkg::MulW'(t_reg);
                            mul_b = vdm_pkg::MulW'(q_reg);
                        end
                        2'd1:
                        begin
                            mul_a = vdm_pkg::MulW'(t_reg);
                            mul_b = vdm_pkg::MulW'(t_reg);
                        end
                        default:
                        begin
                            mul_a = vdm_pkg::MulW'(q_reg);
                            mul_b = vdm_pkg::MulW'(q_reg);
                        end
                    endcase
                end
            end
            vdm_pkg::S_SQ_GO:
            begin
                iter_cmd.start = 1'b1;
                unique case (sq_sel_reg)
                    vdm_pkg::SQ_MAIN:   iter_cmd.num = acc_reg;
                    vdm_pkg::SQ_TARGET: iter_cmd.num = te_reg;
                    default:            iter_cmd.num = qe_reg;
                endcase
            end
            vdm_pkg::S_PROD:
            begin
                mul_en = 1'b1;
                mul_a  = {1'b0, sa_reg};
                mul_b  = {1'b0, sb_reg};
            end
            vdm_pkg::S_CMP:
            begin
                iter_cmd.start    = ({1'b0, mag} < {prod[vdm_pkg::AccW-1:0], 1'b0});
                iter_cmd.div_mode = 1'b1;
                iter_cmd.num      = mag;
                iter_cmd.den      = prod[vdm_pkg::AccW-1:0];
            end
            vdm_pkg::S_OUT:
                out_load = !out_valid_reg || !out_stall;
            default:
                mul_en = 1'b0;
        endcase
    end

    // accumulate one product or difference, or keep the larger difference for L-infinity
    always_comb
    begin
        add_res = {1'b0, acc_reg};
        unique case (metric_reg)
            vdm_pkg::METRIC_L1:
                add_res = vdm_pkg::uadd_sat(acc_reg, vdm_pkg::AccW'(ad));
            vdm_pkg::METRIC_L2:
                add_res = vdm_pkg::uadd_sat(acc_reg, prod[vdm_pkg::AccW-1:0]);
            vdm_pkg::METRIC_LINF:
                add_res = {1'b0, (vdm_pkg::AccW'(ad) > acc_reg) ? vdm_pkg::AccW'(ad) : acc_reg};
            default:
            begin
                unique case (ph_reg)
                    2'd0:    add_res = vdm_pkg::sadd_sat(acc_reg, prod[vdm_pkg::AccW-1:0]);
                    2'd1:    add_res = vdm_pkg::uadd_sat(te_reg, prod[vdm_pkg::AccW-1:0]);
                    default: add_res = vdm_pkg::uadd_sat(qe_reg, prod[vdm_pkg::AccW-1:0]);
                endcase
            end
        endcase
    end

    // final score
    always_comb
    begin
        score_calc = '0;
        sat_calc   = clip_reg;
        unique case (metric_reg)
            vdm_pkg::METRIC_L1:
            begin
                if (acc_reg[vdm_pkg::AccW-1:31] != '0)
                begin
                    score_calc = 32'h7FFF_FFFF;
                    sat_calc   = 1'b1;
                end
                else
                begin
                    score_calc = acc_reg[31:0];
                end
            end
            vdm_pkg::METRIC_L2:
                score_calc = iter_res;
            vdm_pkg::METRIC_LINF:
                score_calc = acc_reg[31:0];
            default:
            begin
                if (undef_reg)
                    score_calc = '0;
                else if (ovf_reg)
                begin
                    score_calc = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    sat_calc   = 1'b1;
                end
                else
                    score_calc = neg ? -{1'b0, iter_res[30:0]} : {1'b0, iter_res[30:0]};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vdm_pkg::S_IDLE;
            metric_reg    <= vdm_pkg::METRIC_L2;
            sq_sel_reg    <= vdm_pkg::SQ_MAIN;
            ph_reg        <= '0;
            acc_reg       <= '0;
            te_reg        <= '0;
            qe_reg        <= '0;
            clip_reg      <= 1'b0;
            undef_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (metric_we)
            begin
                metric_reg <= vdm_pkg::metric_t'(metric_wdata);
                acc_reg    <= '0;
                te_reg     <= '0;
                qe_reg     <= '0;
                clip_reg   <= 1'b0;
            end
            else if (out_load)
            begin
                acc_reg  <= '0;
                te_reg   <= '0;
                qe_reg   <= '0;
                clip_reg <= 1'b0;
            end
            else if (state_reg == vdm_pkg::S_ACC)
            begin
                clip_reg <= clip_reg | add_res[vdm_pkg::AccW];
                if (metric_reg == vdm_pkg::METRIC_COS && ph_reg == 2'd1)
                    te_reg <= add_res[vdm_pkg::AccW-1:0];
                else if (metric_reg == vdm_pkg::METRIC_COS && ph_reg == 2'd2)
                    qe_reg <= add_res[vdm_pkg::AccW-1:0];
                else
                    acc_reg <= add_res[vdm_pkg::AccW-1:0];
            end

            if (accept)
            begin
                ph_reg    <= '0;
                undef_reg <= 1'b0;
                ovf_reg   <= 1'b0;
            end
            if (state_reg == vdm_pkg::S_ACC)
            begin
                ph_reg     <= (metric_reg == vdm_pkg::METRIC_COS && ph_reg != 2'd2) ?
                              ph_reg + 2'd1 : 2'd0;
                sq_sel_reg <= (metric_reg == vdm_pkg::METRIC_COS) ?
                              vdm_pkg::SQ_TARGET : vdm_pkg::SQ_MAIN;
            end
            if (state_reg == vdm_pkg::S_SQ_WAIT && !iter_busy)
            begin
                if (sq_sel_reg == vdm_pkg::SQ_TARGET)
                    sq_sel_reg <= vdm_pkg::SQ_QUERY;
                if (sq_sel_reg == vdm_pkg::SQ_QUERY && (sa_reg == '0 || iter_res[23:0] == '0))
                    undef_reg <= 1'b1;
            end
            if (state_reg == vdm_pkg::S_CMP && state_next == vdm_pkg::S_OUT)
                ovf_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            t_reg    <= target_elem;
            q_reg    <= query_elem;
            last_reg <= last_elem;
        end
        if (state_reg == vdm_pkg::S_SQ_WAIT && !iter_busy)
        begin
            if (sq_sel_reg == vdm_pkg::SQ_TARGET)
                sa_reg <= iter_res[23:0];
            if (sq_sel_reg == vdm_pkg::SQ_QUERY)
                sb_reg <= iter_res[23:0];
        end
        if (out_load)
        begin
            score_reg     <= score_calc;
            undefined_reg <= (metric_reg == vdm_pkg::METRIC_COS) && undef_reg;
            saturated_reg <= sat_calc;
        end
    end

    assign in_stall  = state_reg != vdm_pkg::S_IDLE;
    assign out_valid = out_valid_reg;
    assign score     = score_reg;
    assign undefined = undefined_reg;
    assign saturated = saturated_reg;

`include "assert_macros.svh"

    `VDM_ASSERT_IMP(a_undef_zero, clk, rst_n, out_valid && undefined, score == '0)
    `VDM_ASSERT_IMP(a_undef_cos, clk, rst_n, out_valid && undefined, metric_reg == vdm_pkg::METRIC_COS)
    `VDM_ASSERT_IMP(a_iter_idle, clk, rst_n, state_reg == vdm_pkg::S_IDLE, !iter_busy)
    `VDM_ASSERT_NXT(a_accept_mul, clk, rst_n, accept, state_reg == vdm_pkg::S_MUL)

endmodule

FILE: sv/vdm_mul.sv
// shared registered signed multiplier
module vdm_mul
(
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [vdm_pkg::MulW-1:0]     op_a,
    input  logic signed [vdm_pkg::MulW-1:0]     op_b,
    output logic signed [2*vdm_pkg::MulW-1:0]   prod
);

    logic signed [2*vdm_pkg::MulW-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= op_a * op_b;
        end
    end

    assign prod = prod_reg;

endmodule

FILE: sv/vdm_iter.sv
// iterative compare-subtract unit: integer square root and restoring division
module vdm_iter
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  vdm_pkg::iter_cmd_t         cmd,
    output logic                       busy,
    output logic [31:0]                result
);

    localparam logic [4:0] SqrtSteps = 5'd25;
    localparam logic [4:0] DivSteps  = 5'd31;

    logic [vdm_pkg::IterW-1:0] rem_reg, rem_next;
    logic [vdm_pkg::AccW:0]    res_reg, res_next;
    logic [vdm_pkg::AccW:0]    bit_reg, bit_next;
    logic [vdm_pkg::AccW-1:0]  den_reg;
    logic                      div_reg;
    logic [4:0]                cnt_reg, cnt_next;

    logic [vdm_pkg::IterW-1:0] op_a, op_b;
    logic                      ge;

    always_comb
    begin
        op_a = (div_reg && cnt_reg != DivSteps) ? {rem_reg[vdm_pkg::IterW-2:0], 1'b0} : rem_reg;
        op_b = div_reg ? {2'b00, den_reg} : {1'b0, res_reg + bit_reg};
        ge   = op_a >= op_b;
        rem_next = ge ? op_a - op_b : op_a;
        if (div_reg)
            res_next = {res_reg[vdm_pkg::AccW-1:0], ge};
        else
            res_next = ge ? (res_reg >> 1) + bit_reg : res_reg >> 1;
        bit_next = bit_reg >> 2;
        cnt_next = cnt_reg - 5'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.start)
        begin
            cnt_reg <= cmd.div_mode ? DivSteps : SqrtSteps;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rem_reg <= {2'b00, cmd.num};
            res_reg <= '0;
            bit_reg <= {1'b1, {vdm_pkg::AccW{1'b0}}};
            den_reg <= cmd.den;
            div_reg <= cmd.div_mode;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            res_reg <= res_next;
            bit_reg <= bit_next;
        end
    end

    assign busy   = cnt_reg != '0;
    assign result = res_reg[31:0];

endmodule

FILE: bench/tb_vector_distance_metric_unit.sv
// self-checking testbench of the vector distance unit, random and directed vectors
module tb_vector_distance_metric_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint UnsMax = 64'h0000_FFFF_FFFF_FFFF;
    localparam longint SgnMax = 64'h0000_7FFF_FFFF_FFFF;
    localparam longint SgnMin = -64'sh0000_8000_0000_0000;
    localparam int StallLimit = 20000;

    typedef struct {
        logic signed [15:0] t;
        logic signed [15:0] q;
        logic               last;
    } pair_t;

    typedef struct {
        logic signed [31:0] score;
        logic               undef;
        logic               sat;
    } dist_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [15:0] target_elem = '0;
    logic signed [15:0] query_elem = '0;
    logic last_elem = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] score;
    logic undefined;
    logic saturated;
    logic metric_we = 1'b0;
    logic [1:0] metric_wdata = '0;

    pair_t pending_pairs[$];
    dist_t expected_dists[$];

    // predictor state
    vdm_pkg::metric_t metric_sel = vdm_pkg::METRIC_L2;
    longint  dist_acc, tgt_energy, qry_energy;
    bit      clipped;

    bit quiet = 1'b0;
    int mismatches = 0;
    int pairs_sent = 0;
    int dists_seen = 0;
    int idle_cycles = 0;
    int metric_writes = 0;

    vector_distance_metric_unit dut
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .target_elem(target_elem), .query_elem(query_elem), .last_elem(last_elem),
        .out_valid(out_valid), .out_stall(out_stall),
        .score(score), .undefined(undefined), .saturated(saturated),
        .metric_we(metric_we), .metric_wdata(metric_wdata)
    );

    always #4 clk = ~clk;

    function automatic longint floor_sqrt(longint v);
        longint res, bitv;
        res = 0;
        bitv = 64'd1 << 48;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint add_clip(longint acc, longint inc, ref bit clip);
        longint s;
        s = acc + inc;
        if (s > UnsMax)
        begin
            clip = 1'b1;
            return UnsMax;
        end
        return s;
    endfunction

    task automatic clear_sums();
        dist_acc = 0;
        tgt_energy = 0;
        qry_energy = 0;
        clipped = 1'b0;
    endtask

    task automatic predict_pair(pair_t p);
        longint t, q, ad, s, sa, sb, d, mag, quo, rem;
        dist_t r;
        t = p.t;
        q = p.q;
        ad = (t > q) ? t - q : q - t;
        case (metric_sel)
            vdm_pkg::METRIC_L1: dist_acc = add_clip(dist_acc, ad, clipped);
            vdm_pkg::METRIC_L2: dist_acc = add_clip(dist_acc, ad * ad, clipped);
            vdm_pkg::METRIC_LINF: if (ad > dist_acc) dist_acc = ad;
            default:
            begin
                s = dist_acc + t * q;
                if (s > SgnMax)
                begin
                    s = SgnMax;
                    clipped = 1'b1;
                end
                else if (s < SgnMin)
                begin
                    s = SgnMin;
                    clipped = 1'b1;
                end
                dist_acc = s;
                tgt_energy = add_clip(tgt_energy, t * t, clipped);
                qry_energy = add_clip(qry_energy, q * q, clipped);
            end
        endcase
        if (!p.last)
            return;
        r.undef = 1'b0;
        r.sat = clipped;
        case (metric_sel)
            vdm_pkg::METRIC_L1:
                if (dist_acc > 64'sd2147483647)
                begin
                    r.score = 32'sh7FFF_FFFF;
                    r.sat = 1'b1;
                end
                else
                    r.score = dist_acc[31:0];
            vdm_pkg::METRIC_L2: r.score = 32'(floor_sqrt(dist_acc));
            vdm_pkg::METRIC_LINF: r.score = dist_acc[31:0];
            default:
            begin
                sa = floor_sqrt(tgt_energy);
                sb = floor_sqrt(qry_energy);
                if (sa == 0 || sb == 0)
                begin
                    r.score = 0;
                    r.undef = 1'b1;
                end
                else
                begin
                    d = sa * sb;
                    mag = (dist_acc < 0) ? -dist_acc : dist_acc;
                    quo = mag / d;
                    rem = mag % d;
                    if (quo >= 2)
                    begin
                        r.sat = 1'b1;
                        r.score = (dist_acc < 0) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    end
                    else
                    begin
                        for (int i = 0; i < 30; i++)
                        begin
                            rem = rem << 1;
                            quo = quo << 1;
                            if (rem >= d)
                            begin
                                rem = rem - d;
                                quo = quo | 1;
                            end
                        end
                        r.score = 32'((dist_acc < 0) ? -quo : quo);
                    end
                end
            end
        endcase
        expected_dists.push_back(r);
        clear_sums();
    endtask

    // driver: predicts each accepted item, then offers the next one
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_pair('{target_elem, query_elem, last_elem});
                pairs_sent++;
            end
            if ((in_valid && in_stall) ||
                (pending_pairs.size() > 0 && (quiet || $urandom_range(99) >= 19)))
            begin
                if (!(in_valid && in_stall))
                begin
                    pair_t p;
                    p = pending_pairs.pop_front();
                    target_elem <= p.t;
                    query_elem <= p.q;
                    last_elem <= p.last;
                end
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_stall <= !quiet && ($urandom_range(99) < 19);
            if (out_valid && !out_stall)
            begin
                dists_seen++;
                if (expected_dists.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result score=%0d", score);
                end
                else
                begin
                    dist_t e;
                    e = expected_dists.pop_front();
                    if (score !== e.score || undefined !== e.undef || saturated !== e.sat)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: score %0d/%0d undefined %b/%b saturated %b/%b",
                                     e.score, score, e.undef, undefined, e.sat, saturated);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any accepted item or metric write
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || metric_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic signed [15:0] pick_elem();
        case ($urandom_range(5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($signed($urandom_range(511)) - 256);
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic add_vector(int len);
        for (int i = 0; i < len; i++)
            pending_pairs.push_back('{pick_elem(), pick_elem(), i == len - 1});
    endtask

    task automatic add_pair(logic signed [15:0] t, logic signed [15:0] q, logic last);
        pending_pairs.push_back('{t, q, last});
    endtask

    // lets the block run dry until all pairs are sent and all results checked, then idles on
    task automatic drain();
        while (pending_pairs.size() > 0 || in_valid || expected_dists.size() > 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_metric(vdm_pkg::metric_t m);
        @(posedge clk);
        metric_we <= 1'b1;
        metric_wdata <= m;
        @(posedge clk);
        metric_we <= 1'b0;
        metric_sel = m;
        clear_sums();
        metric_writes++;
    endtask

    task automatic directed_set();
        add_pair(16'sh7FFF, 16'sh8000, 1'b1);
        add_pair(16'sh8000, 16'sh7FFF, 1'b0);
        add_pair(16'sh0000, 16'sh0000, 1'b1);
        add_pair(16'sh0000, 16'sh1234, 1'b0);
        add_pair(16'sh0000, 16'sh8000, 1'b1);
        add_pair(16'sh8000, 16'sh8000, 1'b0);
        add_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
    endtask

    initial
    begin
        clear_sums();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        // reset metric is L2
        directed_set();
        drain();
        for (int m = 0; m < 4; m++)
        begin
            write_metric(vdm_pkg::metric_t'(m));
            directed_set();
            drain();
        end
        // cosine with opposite and orthogonal vectors
        add_pair(16'sh0100, -16'sh0100, 1'b0);
        add_pair(16'sh0200, -16'sh0200, 1'b1);
        add_pair(16'sh0100, 16'sh0000, 1'b0);
        add_pair(16'sh0000, 16'sh0100, 1'b1);
        drain();
        for (int ph = 0; ph < 10; ph++)
        begin
            int budget;
            write_metric(ph < 4 ? vdm_pkg::metric_t'(ph) :
                         vdm_pkg::metric_t'($urandom_range(3)));
            quiet = (ph == 5);
            budget = 80;
            while (budget > 0)
            begin
                int len;
                len = ($urandom_range(9) == 0) ? $urandom_range(64, 20) : $urandom_range(8, 1);
                add_vector(len);
                budget -= len;
            end
            drain();
            quiet = 1'b0;
        end
        $display("sent %0d element pairs, checked %0d results over %0d metric settings",
                 pairs_sent, dists_seen, metric_writes);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/vdm_pkg.sv
sv/vdm_mul.sv
sv/vdm_iter.sv
sv/vector_distance_metric_unit.sv
bench/tb_vector_distance_metric_unit.sv
